// ===== hdl/free_extent_heap_allocator_defines.svh =====
// assertion macros for the allocator datapath rtl
`ifndef FREE_EXTENT_HEAP_ALLOCATOR_DEFINES_SVH
`define FREE_EXTENT_HEAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define FEA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fea assertion failed");
`define FEA_ASSERT_RST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("fea reset assertion failed");
`else
`define FEA_ASSERT(name, clk, rst_n, prop)
`define FEA_ASSERT_RST(name, clk, prop)
`endif

`endif

// ===== hdl/fea_pkg.sv =====
// constants, command codes and status type of the free extent heap allocator
`timescale 1ns / 1ps
package fea_pkg;

  localparam int FREE_ENTRIES  = 64;
  localparam int USED_ENTRIES  = 64;
  localparam int GROW_BYTES    = 4096;
  localparam int GROW_LG       = $clog2(GROW_BYTES);
  localparam int HEADER_BYTES  = 16;
  localparam int HEAP_CAPACITY = 16777216;

  localparam int OFF_W   = 24;
  localparam int BYTES_W = 25;
  localparam int CNT_W   = $clog2(FREE_ENTRIES + 1);
  localparam int UCNT_W  = $clog2(USED_ENTRIES + 1);
  localparam int IDX_W   = (CNT_W > UCNT_W) ? CNT_W : UCNT_W;
  localparam int FA_W    = $clog2(FREE_ENTRIES);
  localparam int UA_W    = $clog2(USED_ENTRIES);
  localparam int STEP_W  = BYTES_W - GROW_LG + 1;

  localparam int IN_W  = 48;
  localparam int OUT_W = 112;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INFO  = 2'd2;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic REG_FIT_POLICY = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef logic [4:0] fea_cmd_t;

  localparam fea_cmd_t CMD_NOP        = 5'd0;
  localparam fea_cmd_t CMD_ACCEPT     = 5'd1;
  localparam fea_cmd_t CMD_SLOT_INIT  = 5'd2;
  localparam fea_cmd_t CMD_SLOT_STEP  = 5'd3;
  localparam fea_cmd_t CMD_ALLOC_INIT = 5'd4;
  localparam fea_cmd_t CMD_SCAN_RD    = 5'd5;
  localparam fea_cmd_t CMD_FIT_EV     = 5'd6;
  localparam fea_cmd_t CMD_GROW_A     = 5'd7;
  localparam fea_cmd_t CMD_GROW_B     = 5'd8;
  localparam fea_cmd_t CMD_GROW_APPLY = 5'd9;
  localparam fea_cmd_t CMD_PUSH_RD    = 5'd10;
  localparam fea_cmd_t CMD_PUSH_WR    = 5'd11;
  localparam fea_cmd_t CMD_PUSH_W0    = 5'd12;
  localparam fea_cmd_t CMD_PICK_RD    = 5'd13;
  localparam fea_cmd_t CMD_PICK_EV    = 5'd14;
  localparam fea_cmd_t CMD_DROP_RD    = 5'd15;
  localparam fea_cmd_t CMD_DROP_WR    = 5'd16;
  localparam fea_cmd_t CMD_DROP_END   = 5'd17;
  localparam fea_cmd_t CMD_USE_WR     = 5'd18;
  localparam fea_cmd_t CMD_FREE_INIT  = 5'd19;
  localparam fea_cmd_t CMD_USED_RD    = 5'd20;
  localparam fea_cmd_t CMD_USED_EV    = 5'd21;
  localparam fea_cmd_t CMD_CO_INIT    = 5'd22;
  localparam fea_cmd_t CMD_CO_CRD     = 5'd23;
  localparam fea_cmd_t CMD_CO_CEV     = 5'd24;
  localparam fea_cmd_t CMD_CO_SRD     = 5'd25;
  localparam fea_cmd_t CMD_CO_SEV     = 5'd26;
  localparam fea_cmd_t CMD_INFO_INIT  = 5'd27;
  localparam fea_cmd_t CMD_INFO_EV    = 5'd28;
  localparam fea_cmd_t CMD_OUT_LOAD   = 5'd29;

  typedef struct packed {
    logic [1:0] in_op;
    logic       size_zero;
    logic       off_zero;
    logic       used_end;
    logic       slot_free;
    logic       idx_end;
    logic       found;
    logic       tail;
    logic       g_zero;
    logic       g_fail;
    logic       push_zero;
    logic       split;
    logic       drop_end;
    logic       used_hit;
    logic       free_full;
    logic       c_end;
    logic       s_end;
    logic       s_self;
    logic       merge;
    logic       out_busy;
  } fea_stat_t;

endpackage

// ===== hdl/fea_dp.sv =====
// datapath: free and used tables, scan registers, growth math and result words
`timescale 1ns / 1ps
`include "free_extent_heap_allocator_defines.svh"
module fea_dp import fea_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  fea_cmd_t           cmd,
  output fea_stat_t          st,
  input  logic [1:0]         in_opcode,
  input  logic [OFF_W-1:0]   in_request_size,
  input  logic [OFF_W-1:0]   in_payload_offset,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [BYTES_W-1:0] cfg_data,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic               out_alloc_ok,
  output logic [OFF_W-1:0]   out_payload_offset,
  output logic [BYTES_W-1:0] out_free_payload_bytes,
  output logic [6:0]         out_free_chunk_count,
  output logic [BYTES_W-1:0] out_largest_free_payload,
  output logic [BYTES_W-1:0] out_smallest_free_payload
);

  logic [OFF_W-1:0]   fmem_s [FREE_ENTRIES];
  logic [BYTES_W-1:0] fmem_b [FREE_ENTRIES];
  logic [OFF_W-1:0]   umem_s [USED_ENTRIES];
  logic [BYTES_W-1:0] umem_b [USED_ENTRIES];

  logic [OFF_W-1:0]   frs_q, urs_q;
  logic [BYTES_W-1:0] frb_q, urb_q;

  logic               fwe, uwe;
  logic [FA_W-1:0]    fwa, fra;
  logic [UA_W-1:0]    ura;
  logic [OFF_W-1:0]   fws;
  logic [BYTES_W-1:0] fwb;

  logic [1:0]         fit_r;
  logic [BYTES_W-1:0] lim_cfg_r;
  logic [OFF_W-1:0]   size_r, off_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [BYTES_W-1:0] heap_r;
  logic [USED_ENTRIES-1:0] valid_r;
  logic [IDX_W-1:0]   idx_r;
  logic [UA_W-1:0]    slot_r;
  logic [FA_W-1:0]    pick_r, t_r;
  logic               found_r, tail_r;
  logic [BYTES_W-1:0] pbytes_r, have_r;
  logic [OFF_W-1:0]   tstart_r;
  logic [STEP_W-1:0]  steps_r, room_r;
  logic [BYTES_W-1:0] add_r;
  logic               gz_r, gfail_r;
  logic [OFF_W-1:0]   ext_s_r, gstart_r, cs_r;
  logic [BYTES_W-1:0] ext_b_r, gbytes_r, cb_r;
  logic [CNT_W-1:0]   c_r, s_r;
  logic               res_ok_r;
  logic [OFF_W-1:0]   res_off_r;
  logic [BYTES_W-1:0] res_sum_r, res_big_r, res_small_r;
  logic [6:0]         res_cnt_r;
  logic               out_valid_r;
  logic               ok_q_r;
  logic [OFF_W-1:0]   off_q_r;
  logic [BYTES_W-1:0] sum_q_r, big_q_r, small_q_r;
  logic [6:0]         cnt_q_r;

  logic [BYTES_W-1:0] total, rem, pay, lim, need, g_add;
  logic [BYTES_W:0]   need_up;
  logic [STEP_W-1:0]  g;
  logic               fits, better, at_tail, split;
  logic [BYTES_W:0]   fend, ce, se;
  logic               fwd, bwd, hit;

  assign total = {1'b0, size_r} + BYTES_W'(HEADER_BYTES);
  assign rem   = frb_q - total;
  assign split = rem > BYTES_W'(HEADER_BYTES);
  assign pay   = (frb_q > BYTES_W'(HEADER_BYTES)) ? frb_q - BYTES_W'(HEADER_BYTES) : '0;
  assign fits  = frb_q >= total;
  assign fend  = (BYTES_W + 1)'(frs_q) + (BYTES_W + 1)'(frb_q);
  assign at_tail = fend == (BYTES_W + 1)'(heap_r);
  assign ce    = (BYTES_W + 1)'(cs_r) + (BYTES_W + 1)'(cb_r);
  assign se    = fend;
  assign fwd   = ce == (BYTES_W + 1)'(frs_q);
  assign bwd   = se == (BYTES_W + 1)'(cs_r);
  assign hit   = valid_r[idx_r[UA_W-1:0]] &&
                 ((BYTES_W)'(urs_q) + BYTES_W'(HEADER_BYTES) == BYTES_W'(off_r));
  assign need    = total - have_r;
  assign need_up = (BYTES_W + 1)'(need) + (BYTES_W + 1)'(GROW_BYTES - 1);
  assign lim     = (lim_cfg_r != '0 && lim_cfg_r < BYTES_W'(HEAP_CAPACITY)) ?
                   lim_cfg_r : BYTES_W'(HEAP_CAPACITY);
  assign g       = (steps_r < room_r) ? steps_r : room_r;
  assign g_add   = BYTES_W'(g) << GROW_LG;

  always_comb begin
    case (fit_r)
      FIT_BEST:  better = !found_r || frb_q < pbytes_r;
      FIT_WORST: better = !found_r || frb_q > pbytes_r;
      default:   better = !found_r;
    endcase
  end

  always_comb begin
    st.in_op     = in_opcode;
    st.size_zero = size_r == '0;
    st.off_zero  = off_r == '0;
    st.used_end  = idx_r == IDX_W'(USED_ENTRIES);
    st.slot_free = !valid_r[idx_r[UA_W-1:0]];
    st.idx_end   = idx_r == IDX_W'(cnt_r);
    st.found     = found_r;
    st.tail      = tail_r;
    st.g_zero    = gz_r;
    st.g_fail    = gfail_r;
    st.push_zero = idx_r == '0;
    st.split     = split;
    st.drop_end  = (IDX_W + 1)'(idx_r) + 1'b1 >= (IDX_W + 1)'(cnt_r);
    st.used_hit  = hit;
    st.free_full = cnt_r == CNT_W'(FREE_ENTRIES);
    st.c_end     = c_r == cnt_r;
    st.s_end     = s_r == cnt_r;
    st.s_self    = s_r == c_r;
    st.merge     = fwd || bwd;
    st.out_busy  = out_valid_r && !out_tready;
  end

  // table port control
  always_comb begin
    fwe = 1'b0;
    fwa = '0;
    fws = '0;
    fwb = '0;
    fra = FA_W'(idx_r);
    ura = idx_r[UA_W-1:0];
    uwe = 1'b0;
    unique case (cmd)
      CMD_GROW_APPLY: begin
        if (!gz_r && tail_r) begin
          fwe = 1'b1;
          fwa = t_r;
          fws = tstart_r;
          fwb = have_r + add_r;
        end
      end
      CMD_PUSH_RD: fra = FA_W'(idx_r - 1'b1);
      CMD_PUSH_WR: begin
        fwe = 1'b1;
        fwa = FA_W'(idx_r);
        fws = frs_q;
        fwb = frb_q;
      end
      CMD_PUSH_W0: begin
        fwe = 1'b1;
        fwa = '0;
        fws = ext_s_r;
        fwb = ext_b_r;
      end
      CMD_PICK_RD: fra = pick_r;
      CMD_PICK_EV: begin
        if (split) begin
          fwe = 1'b1;
          fwa = pick_r;
          fws = frs_q + total[OFF_W-1:0];
          fwb = rem;
        end
      end
      CMD_DROP_RD: fra = FA_W'(idx_r + 1'b1);
      CMD_DROP_WR: begin
        fwe = 1'b1;
        fwa = FA_W'(idx_r);
        fws = frs_q;
        fwb = frb_q;
      end
      CMD_USE_WR: uwe = 1'b1;
      CMD_CO_CRD: fra = FA_W'(c_r);
      CMD_CO_SRD: fra = FA_W'(s_r);
      CMD_CO_SEV: begin
        if (fwd) begin
          fwe = 1'b1;
          fwa = FA_W'(c_r);
          fws = cs_r;
          fwb = cb_r + frb_q;
        end else if (bwd) begin
          fwe = 1'b1;
          fwa = FA_W'(s_r);
          fws = frs_q;
          fwb = frb_q + cb_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fwe) begin
      fmem_s[fwa] <= fws;
      fmem_b[fwa] <= fwb;
    end
    frs_q <= fmem_s[fra];
    frb_q <= fmem_b[fra];
  end

  always_ff @(posedge clk) begin
    if (uwe) begin
      umem_s[slot_r] <= gstart_r;
      umem_b[slot_r] <= gbytes_r;
    end
    urs_q <= umem_s[ura];
    urb_q <= umem_b[ura];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r       <= FIT_FIRST;
      lim_cfg_r   <= '0;
      cnt_r       <= '0;
      heap_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FIT_POLICY: fit_r <= cfg_data[1:0];
          REG_HEAP_LIMIT: lim_cfg_r <= cfg_data;
        endcase
      end
      if (cmd == CMD_OUT_LOAD) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd)
        CMD_ACCEPT: begin
          size_r      <= in_request_size;
          off_r       <= in_payload_offset;
          res_ok_r    <= 1'b0;
          res_off_r   <= '0;
          res_sum_r   <= '0;
          res_cnt_r   <= '0;
          res_big_r   <= '0;
          res_small_r <= '0;
        end
        CMD_SLOT_INIT: idx_r <= '0;
        CMD_SLOT_STEP: begin
          if (idx_r != IDX_W'(USED_ENTRIES)) begin
            if (!valid_r[idx_r[UA_W-1:0]]) begin
              slot_r <= idx_r[UA_W-1:0];
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        CMD_ALLOC_INIT: begin
          idx_r   <= '0;
          found_r <= 1'b0;
          tail_r  <= 1'b0;
          have_r  <= '0;
          t_r     <= '0;
        end
        CMD_FIT_EV: begin
          if (fits && better) begin
            found_r  <= 1'b1;
            pick_r   <= FA_W'(idx_r);
            pbytes_r <= frb_q;
          end
          if (!tail_r && at_tail) begin
            tail_r   <= 1'b1;
            t_r      <= FA_W'(idx_r);
            tstart_r <= frs_q;
            have_r   <= frb_q;
          end
          idx_r <= idx_r + 1'b1;
        end
        CMD_GROW_A: begin
          steps_r <= STEP_W'(need_up >> GROW_LG);
          if (heap_r >= lim || (!tail_r && cnt_r == CNT_W'(FREE_ENTRIES))) begin
            room_r <= '0;
          end else begin
            room_r <= STEP_W'((lim - heap_r) >> GROW_LG);
          end
        end
        CMD_GROW_B: begin
          add_r   <= g_add;
          gz_r    <= g == '0;
          gfail_r <= g < steps_r;
        end
        CMD_GROW_APPLY: begin
          if (!gz_r) begin
            heap_r <= heap_r + add_r;
            if (tail_r) begin
              pick_r <= t_r;
            end else begin
              ext_s_r <= heap_r[OFF_W-1:0];
              ext_b_r <= add_r;
              idx_r   <= IDX_W'(cnt_r);
              pick_r  <= '0;
            end
          end
        end
        CMD_PUSH_WR: idx_r <= idx_r - 1'b1;
        CMD_PUSH_W0: cnt_r <= cnt_r + 1'b1;
        CMD_PICK_EV: begin
          gstart_r <= frs_q;
          gbytes_r <= split ? total : frb_q;
          idx_r    <= IDX_W'(pick_r);
        end
        CMD_DROP_WR:  idx_r <= idx_r + 1'b1;
        CMD_DROP_END: cnt_r <= cnt_r - 1'b1;
        CMD_USE_WR: begin
          valid_r[slot_r] <= 1'b1;
          res_ok_r        <= 1'b1;
          res_off_r       <= gstart_r + OFF_W'(HEADER_BYTES);
        end
        CMD_FREE_INIT: idx_r <= '0;
        CMD_USED_EV: begin
          if (hit) begin
            if (cnt_r != CNT_W'(FREE_ENTRIES)) begin
              valid_r[idx_r[UA_W-1:0]] <= 1'b0;
              ext_s_r <= urs_q;
              ext_b_r <= urb_q;
              idx_r   <= IDX_W'(cnt_r);
            end
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        CMD_CO_INIT: c_r <= '0;
        CMD_CO_CEV: begin
          cs_r <= frs_q;
          cb_r <= frb_q;
          s_r  <= '0;
        end
        CMD_CO_SRD: begin
          if (s_r == cnt_r) begin
            c_r <= c_r + 1'b1;
          end else if (s_r == c_r) begin
            s_r <= s_r + 1'b1;
          end
        end
        CMD_CO_SEV: begin
          if (fwd) begin
            idx_r <= IDX_W'(s_r);
          end else if (bwd) begin
            idx_r <= IDX_W'(c_r);
          end else begin
            s_r <= s_r + 1'b1;
          end
        end
        CMD_INFO_INIT: begin
          idx_r     <= '0;
          res_cnt_r <= 7'(cnt_r);
        end
        CMD_INFO_EV: begin
          res_sum_r <= res_sum_r + pay;
          if (pay > res_big_r) begin
            res_big_r <= pay;
          end
          if (idx_r == '0 || pay < res_small_r) begin
            res_small_r <= pay;
          end
          idx_r <= idx_r + 1'b1;
        end
        CMD_OUT_LOAD: begin
          ok_q_r    <= res_ok_r;
          off_q_r   <= res_off_r;
          sum_q_r   <= res_sum_r;
          cnt_q_r   <= res_cnt_r;
          big_q_r   <= res_big_r;
          small_q_r <= res_small_r;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid                = out_valid_r;
  assign out_alloc_ok              = ok_q_r;
  assign out_payload_offset        = off_q_r;
  assign out_free_payload_bytes    = sum_q_r;
  assign out_free_chunk_count      = cnt_q_r;
  assign out_largest_free_payload  = big_q_r;
  assign out_smallest_free_payload = small_q_r;

  `FEA_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(FREE_ENTRIES))
  `FEA_ASSERT(a_fwrite_live, clk, rst_n, fwe |-> (CNT_W'(fwa) <= cnt_r))
  `FEA_ASSERT(a_heap_cap, clk, rst_n, heap_r <= BYTES_W'(HEAP_CAPACITY))
  `FEA_ASSERT(a_load_free, clk, rst_n, (cmd == CMD_OUT_LOAD) |-> (!out_valid_r || out_tready))
  `FEA_ASSERT_RST(a_reset_empty, clk, !rst_n |=> (cnt_r == '0 && heap_r == '0))

endmodule

// ===== hdl/fea_ctrl.sv =====
// controller state machine sequencing table scans, growth, splits and merges
`timescale 1ns / 1ps
module fea_ctrl import fea_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  fea_stat_t st,
  output fea_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_A_CHK  = 5'd1;
  localparam logic [4:0] S_A_SL   = 5'd2;
  localparam logic [4:0] S_A_INI  = 5'd3;
  localparam logic [4:0] S_A_RD   = 5'd4;
  localparam logic [4:0] S_A_EV   = 5'd5;
  localparam logic [4:0] S_A_NF   = 5'd6;
  localparam logic [4:0] S_A_GB   = 5'd7;
  localparam logic [4:0] S_A_GROW = 5'd8;
  localparam logic [4:0] S_A_PRD  = 5'd9;
  localparam logic [4:0] S_A_PEV  = 5'd10;
  localparam logic [4:0] S_A_USE  = 5'd11;
  localparam logic [4:0] S_P_RD   = 5'd12;
  localparam logic [4:0] S_P_WR   = 5'd13;
  localparam logic [4:0] S_P_W0   = 5'd14;
  localparam logic [4:0] S_D_RD   = 5'd15;
  localparam logic [4:0] S_D_WR   = 5'd16;
  localparam logic [4:0] S_D_END  = 5'd17;
  localparam logic [4:0] S_F_CHK  = 5'd18;
  localparam logic [4:0] S_F_RD   = 5'd19;
  localparam logic [4:0] S_F_EV   = 5'd20;
  localparam logic [4:0] S_C_INIT = 5'd21;
  localparam logic [4:0] S_C_CRD  = 5'd22;
  localparam logic [4:0] S_C_CEV  = 5'd23;
  localparam logic [4:0] S_C_SRD  = 5'd24;
  localparam logic [4:0] S_C_SEV  = 5'd25;
  localparam logic [4:0] S_I_INIT = 5'd26;
  localparam logic [4:0] S_I_RD   = 5'd27;
  localparam logic [4:0] S_I_EV   = 5'd28;
  localparam logic [4:0] S_DONE   = 5'd29;

  logic [4:0] state_r, state_nxt, ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  assign in_tready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd       = CMD_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd = CMD_ACCEPT;
          unique case (st.in_op)
            OP_ALLOC: state_nxt = S_A_CHK;
            OP_FREE:  state_nxt = S_F_CHK;
            OP_INFO:  state_nxt = S_I_INIT;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_A_CHK: begin
        cmd       = CMD_SLOT_INIT;
        state_nxt = st.size_zero ? S_DONE : S_A_SL;
      end
      S_A_SL: begin
        cmd = CMD_SLOT_STEP;
        if (st.used_end) begin
          state_nxt = S_DONE;
        end else if (st.slot_free) begin
          state_nxt = S_A_INI;
        end
      end
      S_A_INI: begin
        cmd       = CMD_ALLOC_INIT;
        state_nxt = S_A_RD;
      end
      S_A_RD: begin
        if (st.idx_end) begin
          state_nxt = S_A_NF;
        end else begin
          cmd       = CMD_SCAN_RD;
          state_nxt = S_A_EV;
        end
      end
      S_A_EV: begin
        cmd       = CMD_FIT_EV;
        state_nxt = S_A_RD;
      end
      S_A_NF: begin
        cmd       = CMD_GROW_A;
        state_nxt = st.found ? S_A_PRD : S_A_GB;
      end
      S_A_GB: begin
        cmd       = CMD_GROW_B;
        state_nxt = S_A_GROW;
      end
      S_A_GROW: begin
        cmd = CMD_GROW_APPLY;
        if (st.g_zero) begin
          state_nxt = S_DONE;
        end else if (st.tail) begin
          state_nxt = st.g_fail ? S_DONE : S_A_PRD;
        end else begin
          ret_nxt   = st.g_fail ? S_DONE : S_A_PRD;
          state_nxt = S_P_RD;
        end
      end
      S_P_RD: begin
        if (st.push_zero) begin
          state_nxt = S_P_W0;
        end else begin
          cmd       = CMD_PUSH_RD;
          state_nxt = S_P_WR;
        end
      end
      S_P_WR: begin
        cmd       = CMD_PUSH_WR;
        state_nxt = S_P_RD;
      end
      S_P_W0: begin
        cmd       = CMD_PUSH_W0;
        state_nxt = ret_r;
      end
      S_A_PRD: begin
        cmd       = CMD_PICK_RD;
        state_nxt = S_A_PEV;
      end
      S_A_PEV: begin
        cmd = CMD_PICK_EV;
        if (st.split) begin
          state_nxt = S_A_USE;
        end else begin
          ret_nxt   = S_A_USE;
          state_nxt = S_D_RD;
        end
      end
      S_D_RD: begin
        if (st.drop_end) begin
          state_nxt = S_D_END;
        end else begin
          cmd       = CMD_DROP_RD;
          state_nxt = S_D_WR;
        end
      end
      S_D_WR: begin
        cmd       = CMD_DROP_WR;
        state_nxt = S_D_RD;
      end
      S_D_END: begin
        cmd       = CMD_DROP_END;
        state_nxt = ret_r;
      end
      S_A_USE: begin
        cmd       = CMD_USE_WR;
        state_nxt = S_DONE;
      end
      S_F_CHK: begin
        cmd       = CMD_FREE_INIT;
        state_nxt = st.off_zero ? S_DONE : S_F_RD;
      end
      S_F_RD: begin
        if (st.used_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_USED_RD;
          state_nxt = S_F_EV;
        end
      end
      S_F_EV: begin
        cmd = CMD_USED_EV;
        if (st.used_hit) begin
          if (st.free_full) begin
            state_nxt = S_DONE;
          end else begin
            ret_nxt   = S_C_INIT;
            state_nxt = S_P_RD;
          end
        end else begin
          state_nxt = S_F_RD;
        end
      end
      S_C_INIT: begin
        cmd       = CMD_CO_INIT;
        state_nxt = S_C_CRD;
      end
      S_C_CRD: begin
        if (st.c_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_CO_CRD;
          state_nxt = S_C_CEV;
        end
      end
      S_C_CEV: begin
        cmd       = CMD_CO_CEV;
        state_nxt = S_C_SRD;
      end
      S_C_SRD: begin
        cmd = CMD_CO_SRD;
        if (st.s_end) begin
          state_nxt = S_C_CRD;
        end else if (!st.s_self) begin
          state_nxt = S_C_SEV;
        end
      end
      S_C_SEV: begin
        cmd = CMD_CO_SEV;
        if (st.merge) begin
          ret_nxt   = S_C_INIT;
          state_nxt = S_D_RD;
        end else begin
          state_nxt = S_C_SRD;
        end
      end
      S_I_INIT: begin
        cmd       = CMD_INFO_INIT;
        state_nxt = S_I_RD;
      end
      S_I_RD: begin
        if (st.idx_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd       = CMD_SCAN_RD;
          state_nxt = S_I_EV;
        end
      end
      S_I_EV: begin
        cmd       = CMD_INFO_EV;
        state_nxt = S_I_RD;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd       = CMD_OUT_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/free_extent_heap_allocator.sv =====
// top level of the free extent heap allocator
`timescale 1ns / 1ps
// Heap allocator over a free-extent table of 64 entries and a used-block table of
// 64 entries, both in memories with one write and one registered read port. One word is
// worked on at a time; the input is taken again once the result is loaded into the
// output register, where that result may still wait. Each table access is a read,
// then an evaluate or write, so the time a word takes grows with table occupancy: info
// scans the free table; alloc searches the used table for a free slot and scans the free
// table, then inserts a new extent on heap growth when no extent ends at the heap top,
// or removes an extent taken whole; free scans the used table, inserts the freed block
// at the head and then repeats pairwise merge passes, starting anew after each merge,
// until a pass merges nothing.
module free_extent_heap_allocator import fea_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // opcode
  input  logic [1:0]         in_tuser,
  // request_size, payload_offset_in
  input  logic [IN_W-1:0]    in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  // alloc_ok, payload_offset_out, free_payload_bytes, free_chunk_count,
  // largest_free_payload, smallest_free_payload
  output logic [OUT_W-1:0]   out_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [BYTES_W-1:0] cfg_data
);

  fea_cmd_t           cmd;
  fea_stat_t          st;
  logic               ok;
  logic [OFF_W-1:0]   off;
  logic [BYTES_W-1:0] sum, big, small_pay;
  logic [6:0]         cnt;

  assign cfg_ready = 1'b1;

  fea_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  fea_dp u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .st                        (st),
    .in_opcode                 (in_tuser),
    .in_request_size           (in_tdata[23:0]),
    .in_payload_offset         (in_tdata[47:24]),
    .cfg_valid                 (cfg_valid),
    .cfg_index                 (cfg_index),
    .cfg_data                  (cfg_data),
    .out_tready                (out_tready),
    .out_tvalid                (out_tvalid),
    .out_alloc_ok              (ok),
    .out_payload_offset        (off),
    .out_free_payload_bytes    (sum),
    .out_free_chunk_count      (cnt),
    .out_largest_free_payload  (big),
    .out_smallest_free_payload (small_pay)
  );

  assign out_tdata = {5'b0, small_pay, big, cnt, sum, off, ok};

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the free extent heap allocator
`timescale 1ns / 1ps
module testbench;
  import fea_pkg::*;

  localparam int CYCLE_LIMIT = 150000000;

  typedef struct packed {
    logic               ok;
    logic [OFF_W-1:0]   offset;
    logic [BYTES_W-1:0] free_sum;
    logic [6:0]         chunks;
    logic [BYTES_W-1:0] biggest;
    logic [BYTES_W-1:0] least;
  } alloc_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [1:0]         in_tuser;
  logic [IN_W-1:0]    in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_W-1:0]   out_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [BYTES_W-1:0] cfg_data;

  free_extent_heap_allocator DUT (.*);

  // allocator state as the testbench predicts it
  longint      ext_start [FREE_ENTRIES];
  longint      ext_bytes [FREE_ENTRIES];
  int          ext_count;
  longint      blk_start [USED_ENTRIES];
  longint      blk_bytes [USED_ENTRIES];
  bit          blk_live  [USED_ENTRIES];
  longint      heap_size;
  logic [1:0]  policy;
  longint      limit_bytes;

  alloc_result_t expected_results[$];
  logic [OFF_W-1:0] live_offsets[$];
  int  errors, cycles, words_sent, words_checked, grants, frees_sent;
  int  idle_pct, stall_pct, hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("free_extent_heap_allocator verification failed");
        $finish;
      end
    end
  end

  function automatic void drop_extent(int idx);
    for (int i = idx; i + 1 < ext_count; i++) begin
      ext_start[i] = ext_start[i+1];
      ext_bytes[i] = ext_bytes[i+1];
    end
    ext_count--;
  endfunction

  function automatic bit push_extent(longint st, longint by);
    if (ext_count >= FREE_ENTRIES) return 1'b0;
    for (int i = ext_count; i > 0; i--) begin
      ext_start[i] = ext_start[i-1];
      ext_bytes[i] = ext_bytes[i-1];
    end
    ext_start[0] = st;
    ext_bytes[0] = by;
    ext_count++;
    return 1'b1;
  endfunction

  function automatic longint heap_alloc(longint size);
    longint total, pb, have, need, steps, room, lim, g, st, by, rem;
    int slot, pick, t;
    bit found, tail;
    total = HEADER_BYTES + size;
    found = 1'b0;
    tail = 1'b0;
    pick = 0;
    pb = 0;
    t = 0;
    have = 0;
    if (size == 0) return 0;
    slot = USED_ENTRIES;
    for (int i = 0; i < USED_ENTRIES; i++) begin
      if (!blk_live[i]) begin
        slot = i;
        break;
      end
    end
    if (slot >= USED_ENTRIES) return 0;
    for (int i = 0; i < ext_count; i++) begin
      if (ext_bytes[i] < total) continue;
      if (policy == FIT_BEST) begin
        if (!found || ext_bytes[i] < pb) begin
          found = 1'b1; pick = i; pb = ext_bytes[i];
        end
      end else if (policy == FIT_WORST) begin
        if (!found || ext_bytes[i] > pb) begin
          found = 1'b1; pick = i; pb = ext_bytes[i];
        end
      end else begin
        found = 1'b1; pick = i;
        break;
      end
    end
    if (!found) begin
      for (int i = 0; i < ext_count; i++) begin
        if (ext_start[i] + ext_bytes[i] == heap_size) begin
          tail = 1'b1; t = i; have = ext_bytes[i];
          break;
        end
      end
      need = total - have;
      steps = (need + GROW_BYTES - 1) / GROW_BYTES;
      lim = HEAP_CAPACITY;
      if (limit_bytes != 0 && limit_bytes < lim) lim = limit_bytes;
      room = (heap_size >= lim) ? 0 : (lim - heap_size) / GROW_BYTES;
      if (!tail && ext_count >= FREE_ENTRIES) room = 0;
      g = (steps < room) ? steps : room;
      if (g > 0) begin
        if (tail) begin
          ext_bytes[t] += g * GROW_BYTES;
        end else begin
          void'(push_extent(heap_size, g * GROW_BYTES));
          t = 0;
        end
        heap_size += g * GROW_BYTES;
      end
      if (g < steps) return 0;
      pick = t;
    end
    st = ext_start[pick];
    by = ext_bytes[pick];
    rem = by - total;
    if (rem > HEADER_BYTES) begin
      ext_start[pick] = st + total;
      ext_bytes[pick] = rem;
      by = total;
    end else begin
      drop_extent(pick);
    end
    blk_start[slot] = st;
    blk_bytes[slot] = by;
    blk_live[slot] = 1'b1;
    return (st + HEADER_BYTES) & 24'hFFFFFF;
  endfunction

  function automatic void merge_neighbors();
    bit merged;
    longint cs, ce, ss, se;
    merged = 1'b1;
    while (merged) begin
      merged = 1'b0;
      for (int c = 0; c < ext_count && !merged; c++) begin
        cs = ext_start[c];
        ce = cs + ext_bytes[c];
        for (int s = 0; s < ext_count; s++) begin
          if (s == c) continue;
          ss = ext_start[s];
          se = ss + ext_bytes[s];
          if (ce == ss) begin
            ext_bytes[c] += ext_bytes[s];
            drop_extent(s);
            merged = 1'b1;
            break;
          end
          if (se == cs) begin
            ext_bytes[s] += ext_bytes[c];
            drop_extent(c);
            merged = 1'b1;
            break;
          end
        end
      end
    end
  endfunction

  function automatic void heap_free(longint off);
    if (off == 0) return;
    for (int i = 0; i < USED_ENTRIES; i++) begin
      if (blk_live[i] && blk_start[i] + HEADER_BYTES == off) begin
        if (!push_extent(blk_start[i], blk_bytes[i])) return;
        blk_live[i] = 1'b0;
        merge_neighbors();
        return;
      end
    end
  endfunction

  function automatic alloc_result_t predict_word(logic [1:0] op, logic [23:0] size,
                                                 logic [23:0] off);
    alloc_result_t r;
    longint p, sum, big, lo;
    r = '0;
    sum = 0; big = 0; lo = 0;
    if (op == OP_ALLOC) begin
      p = heap_alloc(size);
      r.ok = (p != 0);
      r.offset = p[OFF_W-1:0];
    end else if (op == OP_FREE) begin
      heap_free(off);
    end else if (op == OP_INFO) begin
      for (int i = 0; i < ext_count; i++) begin
        p = (ext_bytes[i] > HEADER_BYTES) ? ext_bytes[i] - HEADER_BYTES : 0;
        sum += p;
        if (p > big) big = p;
        if (i == 0 || p < lo) lo = p;
      end
      r.free_sum = sum[BYTES_W-1:0];
      r.chunks = ext_count[6:0];
      r.biggest = big[BYTES_W-1:0];
      r.least = lo[BYTES_W-1:0];
    end
    return r;
  endfunction

  task automatic send_word(logic [1:0] op, logic [23:0] size, logic [23:0] off);
    alloc_result_t r;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {off, size};
    do @(posedge clk); while (!in_tready);
    r = predict_word(op, size, off);
    expected_results.push_back(r);
    words_sent++;
    if (op == OP_ALLOC && r.ok) begin
      live_offsets.push_back(r.offset);
      grants++;
    end
    if (op == OP_FREE) frees_sent++;
  endtask

  task automatic send_free_live();
    int k;
    logic [23:0] off;
    if (live_offsets.size() == 0) begin
      send_word(OP_FREE, 24'($urandom), 24'd0);
      return;
    end
    k = $urandom_range(live_offsets.size() - 1);
    off = live_offsets[k];
    live_offsets.delete(k);
    send_word(OP_FREE, 24'($urandom), off);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [BYTES_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FIT_POLICY) policy = val[1:0];
    else limit_bytes = val;
  endtask

  always @(posedge clk) begin
    alloc_result_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[0], out_tdata[24:1], out_tdata[49:25], out_tdata[56:50],
             out_tdata[81:57], out_tdata[106:82]};
      words_checked++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, out_tdata);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.ok !== exp_r.ok) begin
          $display("%0t: alloc_ok exp %0d got %0d", $realtime, exp_r.ok, got.ok);
          errors++;
        end
        if (got.offset !== exp_r.offset) begin
          $display("%0t: payload_offset_out exp %0d got %0d", $realtime,
                   exp_r.offset, got.offset);
          errors++;
        end
        if (got.free_sum !== exp_r.free_sum) begin
          $display("%0t: free_payload_bytes exp %0d got %0d", $realtime,
                   exp_r.free_sum, got.free_sum);
          errors++;
        end
        if (got.chunks !== exp_r.chunks) begin
          $display("%0t: free_chunk_count exp %0d got %0d", $realtime,
                   exp_r.chunks, got.chunks);
          errors++;
        end
        if (got.biggest !== exp_r.biggest) begin
          $display("%0t: largest_free_payload exp %0d got %0d", $realtime,
                   exp_r.biggest, got.biggest);
          errors++;
        end
        if (got.least !== exp_r.least) begin
          $display("%0t: smallest_free_payload exp %0d got %0d", $realtime,
                   exp_r.least, got.least);
          errors++;
        end
      end
    end
  end

  // receiver ready, with a counted long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic test_basics();
    send_word(OP_INFO, 24'd0, 24'd0);
    send_word(OP_ALLOC, 24'd0, 24'd0);
    send_word(OP_ALLOC, 24'd1, 24'd0);
    send_word(OP_ALLOC, 24'd4080, 24'd0);
    send_word(OP_ALLOC, 24'd3000, 24'd0);
    send_word(OP_INFO, 24'd0, 24'd0);
    send_word(OP_FREE, 24'd0, 24'd0);
    send_word(OP_FREE, 24'd0, 24'hFFFFFF);
    send_word(2'd3, 24'hFFFFFF, 24'hFFFFFF);
    while (live_offsets.size() != 0) send_free_live();
    send_word(OP_INFO, 24'd0, 24'd0);
  endtask

  task automatic test_heap_limit();
    write_reg(REG_HEAP_LIMIT, 25'd12288);
    send_word(OP_ALLOC, 24'd20000, 24'd0);
    send_word(OP_ALLOC, 24'd8000, 24'd0);
    send_word(OP_INFO, 24'd0, 24'd0);
    write_reg(REG_HEAP_LIMIT, 25'd4096);
    send_word(OP_ALLOC, 24'd6000, 24'd0);
    write_reg(REG_HEAP_LIMIT, 25'd16777216);
    send_word(OP_ALLOC, 24'd6000, 24'd0);
    while (live_offsets.size() != 0) send_free_live();
    write_reg(REG_HEAP_LIMIT, 25'd0);
  endtask

  task automatic test_used_table_full();
    for (int i = 0; i < USED_ENTRIES + 2; i++) send_word(OP_ALLOC, 24'd48, 24'd0);
    send_word(OP_INFO, 24'd0, 24'd0);
    for (int i = live_offsets.size() - 1; i >= 0; i -= 2) begin
      send_word(OP_FREE, 24'd0, live_offsets[i]);
      live_offsets.delete(i);
    end
    send_word(OP_INFO, 24'd0, 24'd0);
  endtask

  task automatic random_phase(int count, int alloc_w);
    int pick;
    logic [23:0] size;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < alloc_w) begin
        case ($urandom_range(49))
          0:        size = 24'($urandom);
          1, 2, 3:  size = 24'($urandom_range(20000, 1));
          4:        size = 24'd0;
          default:  size = 24'($urandom_range(160, 1));
        endcase
        send_word(OP_ALLOC, size, 24'($urandom));
      end else if (pick < alloc_w + 33) begin
        if ($urandom_range(9) == 0) send_word(OP_FREE, 24'($urandom), 24'($urandom));
        else send_free_live();
      end else if (pick < 96) begin
        send_word(OP_INFO, 24'($urandom), 24'($urandom));
      end else begin
        send_word(2'd3, 24'($urandom), 24'($urandom));
      end
    end
  endtask

  task automatic test_random();
    int idle_modes[4] = '{0, 88, 0, 34};
    int stall_modes[4] = '{0, 0, 88, 34};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_FIT_POLICY, BYTES_W'(ph % 4));
      idle_pct = idle_modes[ph % 4];
      stall_pct = stall_modes[ph % 4];
      random_phase(90, (ph < 4) ? 55 : 45);
    end
    idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_FIT_POLICY, BYTES_W'(FIT_BEST));
  endtask

  task automatic test_output_backpressure();
    drain();
    hold_cycles = 3000;
    random_phase(40, 50);
  endtask

  task automatic test_whole_capacity();
    write_reg(REG_FIT_POLICY, BYTES_W'(FIT_WORST));
    send_word(OP_ALLOC, 24'hFFFFFF, 24'd0);
    send_word(OP_INFO, 24'd0, 24'd0);
    random_phase(60, 50);
    send_word(OP_ALLOC, 24'hFFFFF0, 24'd0);
    while (live_offsets.size() != 0) send_free_live();
    send_word(OP_INFO, 24'd0, 24'd0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    errors = 0; words_sent = 0; words_checked = 0; grants = 0; frees_sent = 0;
    idle_pct = 0; stall_pct = 0; hold_cycles = 0;
    policy = FIT_FIRST; limit_bytes = 0; ext_count = 0; heap_size = 0;
    for (int i = 0; i < USED_ENTRIES; i++) blk_live[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basics();
    test_heap_limit();
    test_used_table_full();
    test_random();
    test_output_backpressure();
    test_whole_capacity();
    drain();
    repeat (300) @(posedge clk);
    $display("%0d words sent, %0d results checked, %0d grants, %0d frees",
             words_sent, words_checked, grants, frees_sent);
    $display("all fit policies, heap limits, full used table, stalls and full heap covered");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("free_extent_heap_allocator verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_results.size());
      $display("free_extent_heap_allocator verification failed");
    end
    $finish;
  end

endmodule
